// ----- hdl/s5hp_pkg.sv -----
package s5hp_pkg;

  localparam int unsigned BCNT_W = 3;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_ERROR = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
  localparam logic [7:0] CMD_CONNECT    = 8'h01;
  localparam logic [7:0] RSV_BYTE       = 8'h00;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;

  localparam logic [BCNT_W-1:0] REQ_VER_IDX  = 3'd0;
  localparam logic [BCNT_W-1:0] REQ_CMD_IDX  = 3'd1;
  localparam logic [BCNT_W-1:0] REQ_RSV_IDX  = 3'd2;
  localparam logic [BCNT_W-1:0] REQ_ATYP_IDX = 3'd3;
  localparam logic [BCNT_W-1:0] IPV4_BYTES   = 3'd4;
  localparam logic [BCNT_W-1:0] PORT_BYTES   = 3'd2;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_NMETHODS = 4'd1,
    PH_METHODS  = 4'd2,
    PH_REQUEST  = 4'd3,
    PH_IPV4     = 4'd4,
    PH_DLEN     = 4'd5,
    PH_DOMAIN   = 4'd6,
    PH_PORT     = 4'd7,
    PH_ENDED    = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    EV_REPLY   = 3'd0,
    EV_DBYTE   = 3'd1,
    EV_IPV4    = 3'd2,
    EV_DOMAIN  = 3'd3,
    EV_DENIED  = 3'd4,
    EV_LINKERR = 3'd5
  } event_e;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  out_byte;
    logic [31:0] dest_ipv4;
    logic [15:0] dest_port;
    logic [7:0]  domain_length;
    logic        is_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } step_res_t;

  function automatic res_t make_res(event_e ev, logic [7:0] data, logic [31:0] ip,
                                    logic [15:0] port, logic [7:0] dlen, logic last);
    res_t r;
    r.event_res     = ev;
    r.out_byte      = data;
    r.dest_ipv4     = ip;
    r.dest_port     = port;
    r.domain_length = dlen;
    r.is_last       = last;
    return r;
  endfunction

endpackage

// ----- hdl/s5hp_in_if.sv -----
interface s5hp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source(output valid, output action, output rx_byte, input ready);
  modport sink(input valid, input action, input rx_byte, output ready);
endinterface

// ----- hdl/s5hp_out_if.sv -----
interface s5hp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  out_byte;
  logic [31:0] dest_ipv4;
  logic [15:0] dest_port;
  logic [7:0]  domain_length;
  logic        is_last;

  modport source(output valid, output event_res, output out_byte, output dest_ipv4,
                 output dest_port, output domain_length, output is_last, input ready);
  modport sink(input valid, input event_res, input out_byte, input dest_ipv4,
               input dest_port, input domain_length, input is_last, output ready);
endinterface

// ----- hdl/s5hp_step.sv -----
module s5hp_step
  import s5hp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] action_i,
  input  logic [7:0] rx_byte_i,
  output step_res_t  res_o
);

  phase_e              phase_q, phase_d;
  logic [BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic [7:0]          meth_rem_q, meth_rem_d;
  logic                no_auth_q, no_auth_d;
  logic                hdr_ok_q, hdr_ok_d;
  logic                kind_ipv4_q, kind_ipv4_d;
  logic [31:0]         addr_q, addr_d;
  logic [15:0]         port_q, port_d;
  logic [7:0]          dom_left_q, dom_left_d;
  logic [7:0]          dom_total_q, dom_total_d;

  logic              live;
  logic              take_byte;
  logic              take_err;
  logic              take_start;
  logic [7:0]        meth_left;
  logic              no_auth_nxt;
  logic [BCNT_W-1:0] bcnt_inc;
  logic              deny_nm;
  logic              meth_done;
  logic              req_last;
  logic              atyp_ok;
  logic              deny_req;
  logic              ipv4_done;
  logic              port_done;
  logic [7:0]        dom_left_nxt;
  logic [15:0]       port_nxt;

  assign live         = (phase_q != PH_ENDED);
  assign take_byte    = step_i && (action_i == ACT_BYTE) && live;
  assign take_err     = step_i && (action_i == ACT_ERROR) && live;
  assign take_start   = step_i && (action_i == ACT_START);
  assign meth_left    = meth_rem_q - 8'd1;
  assign no_auth_nxt  = no_auth_q | (rx_byte_i == METHOD_NO_AUTH);
  assign bcnt_inc     = bcnt_q + 3'd1;
  assign deny_nm      = !hdr_ok_q || (rx_byte_i == ZERO_BYTE);
  assign meth_done    = (meth_left == ZERO_BYTE);
  assign req_last     = (bcnt_q == REQ_ATYP_IDX);
  assign atyp_ok      = (rx_byte_i == ATYP_IPV4) || (rx_byte_i == ATYP_DOMAIN);
  assign deny_req     = req_last && (!hdr_ok_q || !atyp_ok);
  assign ipv4_done    = (bcnt_inc >= IPV4_BYTES);
  assign port_done    = (bcnt_inc >= PORT_BYTES);
  assign dom_left_nxt = dom_left_q - 8'd1;
  assign port_nxt     = {port_q[7:0], rx_byte_i};

  always_comb begin
    phase_d = phase_q;
    if (take_start) begin
      phase_d = PH_VERSION;
    end else if (take_err) begin
      phase_d = PH_ENDED;
    end else if (take_byte) begin
      unique case (phase_q)
        PH_VERSION:  phase_d = PH_NMETHODS;
        PH_NMETHODS: phase_d = deny_nm ? PH_ENDED : PH_METHODS;
        PH_METHODS: begin
          if (meth_done) begin
            phase_d = no_auth_nxt ? PH_REQUEST : PH_ENDED;
          end
        end
        PH_REQUEST: begin
          if (deny_req) begin
            phase_d = PH_ENDED;
          end else if (req_last) begin
            phase_d = (rx_byte_i == ATYP_IPV4) ? PH_IPV4 : PH_DLEN;
          end
        end
        PH_IPV4: begin
          if (ipv4_done) begin
            phase_d = PH_PORT;
          end
        end
        PH_DLEN:   phase_d = (rx_byte_i == ZERO_BYTE) ? PH_PORT : PH_DOMAIN;
        PH_DOMAIN: begin
          if (dom_left_nxt == ZERO_BYTE) begin
            phase_d = PH_PORT;
          end
        end
        PH_PORT: begin
          if (port_done) begin
            phase_d = PH_ENDED;
          end
        end
        PH_ENDED: phase_d = PH_ENDED;
        default:  phase_d = PH_ENDED;
      endcase
    end
  end

  always_comb begin
    bcnt_d      = bcnt_q;
    meth_rem_d  = meth_rem_q;
    no_auth_d   = no_auth_q;
    hdr_ok_d    = hdr_ok_q;
    kind_ipv4_d = kind_ipv4_q;
    addr_d      = addr_q;
    port_d      = port_q;
    dom_left_d  = dom_left_q;
    dom_total_d = dom_total_q;
    if (take_start) begin
      bcnt_d      = '0;
      meth_rem_d  = '0;
      no_auth_d   = 1'b0;
      hdr_ok_d    = 1'b1;
      kind_ipv4_d = 1'b0;
      addr_d      = '0;
      port_d      = '0;
      dom_left_d  = '0;
      dom_total_d = '0;
    end else if (take_byte) begin
      case (phase_q)
        PH_VERSION: hdr_ok_d = (rx_byte_i == SOCKS_VER);
        PH_NMETHODS: begin
          if (!deny_nm) begin
            meth_rem_d = rx_byte_i;
            no_auth_d  = 1'b0;
          end
        end
        PH_METHODS: begin
          no_auth_d  = no_auth_nxt;
          meth_rem_d = meth_left;
          if (meth_done && no_auth_nxt) begin
            bcnt_d   = '0;
            hdr_ok_d = 1'b1;
          end
        end
        PH_REQUEST: begin
          bcnt_d = bcnt_inc;
          case (bcnt_q)
            REQ_VER_IDX: begin
              if (rx_byte_i != SOCKS_VER) hdr_ok_d = 1'b0;
            end
            REQ_CMD_IDX: begin
              if (rx_byte_i != CMD_CONNECT) hdr_ok_d = 1'b0;
            end
            REQ_RSV_IDX: begin
              if (rx_byte_i != RSV_BYTE) hdr_ok_d = 1'b0;
            end
            default: begin
              kind_ipv4_d = (rx_byte_i == ATYP_IPV4);
              bcnt_d      = '0;
              addr_d      = '0;
            end
          endcase
        end
        PH_IPV4: begin
          addr_d = {addr_q[23:0], rx_byte_i};
          bcnt_d = ipv4_done ? '0 : bcnt_inc;
          if (ipv4_done) port_d = '0;
        end
        PH_DLEN: begin
          dom_left_d  = rx_byte_i;
          dom_total_d = rx_byte_i;
          if (rx_byte_i == ZERO_BYTE) begin
            bcnt_d = '0;
            port_d = '0;
          end
        end
        PH_DOMAIN: begin
          dom_left_d = dom_left_nxt;
          if (dom_left_nxt == ZERO_BYTE) begin
            bcnt_d = '0;
            port_d = '0;
          end
        end
        PH_PORT: begin
          port_d = port_nxt;
          bcnt_d = bcnt_inc;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    if (take_err) begin
      res_o.cnt   = 2'd1;
      res_o.first = make_res(EV_LINKERR, '0, '0, '0, '0, 1'b1);
    end else if (take_byte) begin
      case (phase_q)
        PH_NMETHODS: begin
          if (deny_nm) begin
            res_o.cnt   = 2'd1;
            res_o.first = make_res(EV_DENIED, '0, '0, '0, '0, 1'b1);
          end
        end
        PH_METHODS: begin
          if (meth_done && no_auth_nxt) begin
            res_o.cnt    = 2'd2;
            res_o.first  = make_res(EV_REPLY, SOCKS_VER, '0, '0, '0, 1'b0);
            res_o.second = make_res(EV_REPLY, METHOD_NO_AUTH, '0, '0, '0, 1'b1);
          end else if (meth_done) begin
            res_o.cnt   = 2'd1;
            res_o.first = make_res(EV_DENIED, '0, '0, '0, '0, 1'b1);
          end
        end
        PH_REQUEST: begin
          if (deny_req) begin
            res_o.cnt   = 2'd1;
            res_o.first = make_res(EV_DENIED, '0, '0, '0, '0, 1'b1);
          end
        end
        PH_DOMAIN: begin
          res_o.cnt   = 2'd1;
          res_o.first = make_res(EV_DBYTE, rx_byte_i, '0, '0, '0, 1'b1);
        end
        PH_PORT: begin
          if (port_done && kind_ipv4_q) begin
            res_o.cnt   = 2'd1;
            res_o.first = make_res(EV_IPV4, '0, addr_q, port_nxt, '0, 1'b1);
          end else if (port_done) begin
            res_o.cnt   = 2'd1;
            res_o.first = make_res(EV_DOMAIN, '0, '0, port_nxt, dom_total_q, 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_VERSION;
      bcnt_q      <= '0;
      meth_rem_q  <= '0;
      no_auth_q   <= 1'b0;
      hdr_ok_q    <= 1'b1;
      kind_ipv4_q <= 1'b0;
      addr_q      <= '0;
      port_q      <= '0;
      dom_left_q  <= '0;
      dom_total_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bcnt_q      <= bcnt_d;
      meth_rem_q  <= meth_rem_d;
      no_auth_q   <= no_auth_d;
      hdr_ok_q    <= hdr_ok_d;
      kind_ipv4_q <= kind_ipv4_d;
      addr_q      <= addr_d;
      port_q      <= port_d;
      dom_left_q  <= dom_left_d;
      dom_total_q <= dom_total_d;
    end
  end

  a_ended_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_ENDED) && (action_i != ACT_START)) |-> (res_o.cnt == 2'd0))
    else $error("Ended session produced a result.");

  a_pair_is_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.cnt == 2'd2) |-> ((res_o.first.event_res == EV_REPLY) && !res_o.first.is_last
                             && res_o.second.is_last))
    else $error("Two-result step is not the method reply.");

  a_phase_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q))
    else $error("Phase changed without a transaction.");

endmodule

// ----- hdl/s5hp_out_buf.sv -----
module s5hp_out_buf
  import s5hp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  step_res_t         res_i,
  output logic              space_o,
  s5hp_out_if.source        out_o
);

  logic out_valid_q, out_valid_d;
  logic pend_valid_q, pend_valid_d;
  res_t out_q, out_d;
  res_t pend_q, pend_d;
  logic out_fire;

  assign out_fire = out_valid_q && out_o.ready;
  assign space_o  = !pend_valid_q && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d  = out_valid_q && !out_fire;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    if (pend_valid_q && out_fire) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (load_i && (res_i.cnt != 2'd0)) begin
      out_d        = res_i.first;
      out_valid_d  = 1'b1;
      pend_d       = res_i.second;
      pend_valid_d = (res_i.cnt == 2'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_res     = out_q.event_res;
  assign out_o.out_byte      = out_q.out_byte;
  assign out_o.dest_ipv4     = out_q.dest_ipv4;
  assign out_o.dest_port     = out_q.dest_port;
  assign out_o.domain_length = out_q.domain_length;
  assign out_o.is_last       = out_q.is_last;

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("Second result held without a first result in front of it.");

  a_follower_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_last) |-> pend_valid_q)
    else $error("Non-final result has no follower queued.");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (res_i.cnt != 2'd0)) |-> space_o)
    else $error("Result loaded with no room in the buffer.");

endmodule

// ----- hdl/socks5_handshake_parser_core.sv -----
// Channel  Direction  Payload                                             Handshake
// in_i     sink       action, rx_byte                                     valid/ready
// out_o    source     event_res, out_byte, dest_ipv4, dest_port,          valid/ready
//                     domain_length, is_last
//
// A transaction is registered on entry, decoded from the input register and its results are
// written to the output register, which presents the first result on out_o. One input
// transaction per cycle is sustained while out_o is ready; the method reply step holds the
// next transaction in the input register until its second result moves up from the pending
// entry of the two-entry result buffer into the output register.
// Reset clears the session state to await the greeting version byte and empties both stages.
// A stall on out_o while a result waits in the output register holds every step, and in_i
// then accepts transactions only until the input register is occupied.
module socks5_handshake_parser_core
  import s5hp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  s5hp_in_if.sink     in_i,
  s5hp_out_if.source  out_o
);

  logic       in_valid_q;
  logic [1:0] in_action_q;
  logic [7:0] in_byte_q;
  logic       space;
  logic       step;
  step_res_t  step_res;

  assign step       = in_valid_q && space;
  assign in_i.ready = !in_valid_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_action_q <= in_i.action;
      in_byte_q   <= in_i.rx_byte;
    end
  end

  s5hp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .action_i  (in_action_q),
    .rx_byte_i (in_byte_q),
    .res_o     (step_res)
  );

  s5hp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (step_res),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

// ----- tb/sv/socks5_handshake_parser_core_tb.sv -----
module socks5_handshake_parser_core_tb
  import s5hp_pkg::*;
;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {
    FLT_NONE,
    FLT_GREET_VER,
    FLT_ZERO_COUNT,
    FLT_NO_AUTH,
    FLT_REQ_VER,
    FLT_REQ_CMD,
    FLT_REQ_RSV,
    FLT_ATYP,
    FLT_LINK
  } fault_e;

  class handshake_tracker;
    phase_e      phase;
    logic [7:0]  byte_idx;
    logic [7:0]  methods_left;
    logic        no_auth;
    logic        hdr_ok;
    logic [7:0]  atyp;
    logic [31:0] ip_acc;
    logic [15:0] port_acc;
    logic [7:0]  name_left;
    logic [7:0]  name_len;
    res_t        awaited[$];
    int          errors;
    int          checked;
    int          seen[6];

    function new();
      clear();
    endfunction

    function void clear();
      phase        = PH_VERSION;
      byte_idx     = '0;
      methods_left = '0;
      no_auth      = 1'b0;
      hdr_ok       = 1'b1;
      atyp         = '0;
      ip_acc       = '0;
      port_acc     = '0;
      name_left    = '0;
      name_len     = '0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void push_event(event_e ev, logic [7:0] data, logic [31:0] ip,
                             logic [15:0] port, logic [7:0] dlen, logic last);
      res_t r;
      r.event_res     = ev;
      r.out_byte      = data;
      r.dest_ipv4     = ip;
      r.dest_port     = port;
      r.domain_length = dlen;
      r.is_last       = last;
      awaited.push_back(r);
    endfunction

    function void deny();
      phase = PH_ENDED;
      push_event(EV_DENIED, '0, '0, '0, '0, 1'b1);
    endfunction

    function void enter_port();
      phase    = PH_PORT;
      byte_idx = '0;
      port_acc = '0;
    endfunction

    // Returns 0 when the transaction is ignored by the block.
    function bit take_rx(logic [1:0] act, logic [7:0] b);
      if (act == ACT_START) begin
        clear();
        return 1'b1;
      end
      if (act == ACT_UNUSED || phase == PH_ENDED) return 1'b0;
      if (act == ACT_ERROR) begin
        phase = PH_ENDED;
        push_event(EV_LINKERR, '0, '0, '0, '0, 1'b1);
        return 1'b1;
      end
      case (phase)
        PH_VERSION: begin
          hdr_ok = (b == SOCKS_VER);
          phase  = PH_NMETHODS;
        end
        PH_NMETHODS: begin
          if (!hdr_ok || b == ZERO_BYTE) begin
            deny();
          end else begin
            methods_left = b;
            no_auth      = 1'b0;
            phase        = PH_METHODS;
          end
        end
        PH_METHODS: begin
          if (b == METHOD_NO_AUTH) no_auth = 1'b1;
          methods_left = methods_left - 8'd1;
          if (methods_left == 8'd0) begin
            if (!no_auth) begin
              deny();
            end else begin
              phase    = PH_REQUEST;
              byte_idx = '0;
              hdr_ok   = 1'b1;
              push_event(EV_REPLY, SOCKS_VER, '0, '0, '0, 1'b0);
              push_event(EV_REPLY, METHOD_NO_AUTH, '0, '0, '0, 1'b1);
            end
          end
        end
        PH_REQUEST: begin
          if (byte_idx == REQ_VER_IDX) begin
            if (b != SOCKS_VER) hdr_ok = 1'b0;
          end else if (byte_idx == REQ_CMD_IDX) begin
            if (b != CMD_CONNECT) hdr_ok = 1'b0;
          end else if (byte_idx == REQ_RSV_IDX) begin
            if (b != RSV_BYTE) hdr_ok = 1'b0;
          end
          if (byte_idx != REQ_ATYP_IDX) begin
            byte_idx = byte_idx + 8'd1;
          end else begin
            atyp     = b;
            byte_idx = '0;
            if (!hdr_ok) begin
              deny();
            end else if (b == ATYP_IPV4) begin
              phase  = PH_IPV4;
              ip_acc = '0;
            end else if (b == ATYP_DOMAIN) begin
              phase = PH_DLEN;
            end else begin
              deny();
            end
          end
        end
        PH_IPV4: begin
          ip_acc   = {ip_acc[23:0], b};
          byte_idx = byte_idx + 8'd1;
          if (byte_idx >= IPV4_BYTES) enter_port();
        end
        PH_DLEN: begin
          name_left = b;
          name_len  = b;
          if (b == ZERO_BYTE) enter_port();
          else phase = PH_DOMAIN;
        end
        PH_DOMAIN: begin
          name_left = name_left - 8'd1;
          if (name_left == 8'd0) enter_port();
          push_event(EV_DBYTE, b, '0, '0, '0, 1'b1);
        end
        PH_PORT: begin
          port_acc = {port_acc[7:0], b};
          byte_idx = byte_idx + 8'd1;
          if (byte_idx >= PORT_BYTES) begin
            phase = PH_ENDED;
            if (atyp == ATYP_IPV4) push_event(EV_IPV4, '0, ip_acc, port_acc, '0, 1'b1);
            else push_event(EV_DOMAIN, '0, '0, port_acc, name_len, 1'b1);
          end
        end
        default: begin
        end
      endcase
      return 1'b1;
    endfunction

    task flag(string msg);
      errors++;
      if (errors <= 40) $display("ERROR: %s", msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        flag($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", checked, name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with no expectation pending, event %0d", got.event_res));
        return;
      end
      want = awaited.pop_front();
      checked++;
      seen[want.event_res]++;
      cmp_field("event_res", 32'(got.event_res), 32'(want.event_res));
      cmp_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      cmp_field("dest_ipv4", got.dest_ipv4, want.dest_ipv4);
      cmp_field("dest_port", 32'(got.dest_port), 32'(want.dest_port));
      cmp_field("domain_length", 32'(got.domain_length), 32'(want.domain_length));
      cmp_field("is_last", 32'(got.is_last), 32'(want.is_last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  s5hp_in_if  in_if();
  s5hp_out_if out_if();

  socks5_handshake_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  handshake_tracker tracker = new();

  bit calm;
  int gap_pct;
  int accepted_items;
  int sessions;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("socks5_handshake_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    int stall;
    int mode_left;
    int stall_pct;
    res_t got;
    out_if.ready = 1'b0;
    stall = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.event_res     = out_if.event_res;
        got.out_byte      = out_if.out_byte;
        got.dest_ipv4     = out_if.dest_ipv4;
        got.dest_port     = out_if.dest_port;
        got.domain_length = out_if.domain_length;
        got.is_last       = out_if.is_last;
        tracker.check_result(got);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      mode_left--;
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!calm && rst_ni && $urandom_range(0, 99) < stall_pct) begin
        stall = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [1:0] act, logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (tracker.take_rx(act, b)) accepted_items++;
  endtask

  function automatic logic [7:0] other_than(logic [7:0] a, logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom); while (b == a || b == c);
    return b;
  endfunction

  task automatic random_session();
    fault_e     fault;
    logic [7:0] seq[$];
    logic [7:0] b;
    int         n;
    int         zero_at;
    int         len;
    int         cut;
    bit         use_ipv4;
    fault = FLT_NONE;
    if ($urandom_range(0, 99) >= 65) fault = fault_e'($urandom_range(1, 8));
    case ($urandom_range(0, 2))
      0: gap_pct = 0;
      1: gap_pct = 10;
      default: gap_pct = 35;
    endcase

    seq.push_back(fault == FLT_GREET_VER ? other_than(SOCKS_VER, SOCKS_VER) : SOCKS_VER);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
    if (fault == FLT_ZERO_COUNT) n = 0;
    seq.push_back(n[7:0]);
    zero_at = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      if (fault == FLT_NO_AUTH) b = other_than(METHOD_NO_AUTH, METHOD_NO_AUTH);
      else if (i == zero_at) b = METHOD_NO_AUTH;
      else b = 8'($urandom);
      seq.push_back(b);
    end
    cut = seq.size();

    if (fault != FLT_GREET_VER && fault != FLT_ZERO_COUNT && fault != FLT_NO_AUTH) begin
      use_ipv4 = 1'($urandom_range(0, 1));
      seq.push_back(fault == FLT_REQ_VER ? other_than(SOCKS_VER, SOCKS_VER) : SOCKS_VER);
      seq.push_back(fault == FLT_REQ_CMD ? other_than(CMD_CONNECT, CMD_CONNECT) : CMD_CONNECT);
      seq.push_back(fault == FLT_REQ_RSV ? other_than(RSV_BYTE, RSV_BYTE) : RSV_BYTE);
      if (fault == FLT_ATYP) seq.push_back(other_than(ATYP_IPV4, ATYP_DOMAIN));
      else seq.push_back(use_ipv4 ? ATYP_IPV4 : ATYP_DOMAIN);
      cut = seq.size();
      if (fault == FLT_NONE || fault == FLT_LINK) begin
        if (use_ipv4) begin
          repeat (4) seq.push_back(8'($urandom));
        end else begin
          len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 12);
          seq.push_back(len[7:0]);
          repeat (len) seq.push_back(8'($urandom));
        end
        repeat (2) seq.push_back(8'($urandom));
        cut = seq.size();
      end
    end
    if (fault == FLT_LINK) cut = $urandom_range(0, seq.size());

    send(ACT_START, 8'($urandom));
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 29) == 0) send(ACT_UNUSED, 8'($urandom));
      send(ACT_BYTE, seq[i]);
    end
    if (fault == FLT_LINK) send(ACT_ERROR, 8'($urandom));
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) send(2'($urandom_range(0, 1)), 8'($urandom));
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.action  = ACT_BYTE;
    in_if.rx_byte = '0;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    gap_pct       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bad greeting version straight out of reset, then traffic on an ended session.
    send(ACT_BYTE, 8'h04);
    send(ACT_BYTE, 8'h01);
    send(ACT_BYTE, SOCKS_VER);
    send(ACT_ERROR, 8'hFF);
    send(ACT_UNUSED, 8'hFF);
    // Empty method list.
    send(ACT_START, 8'h00);
    send(ACT_BYTE, SOCKS_VER);
    send(ACT_BYTE, ZERO_BYTE);
    // Method list without no-authentication.
    send(ACT_START, 8'hFF);
    send(ACT_BYTE, SOCKS_VER);
    send(ACT_BYTE, 8'h01);
    send(ACT_BYTE, 8'hFF);
    // Empty domain name with the largest port.
    send(ACT_START, 8'h00);
    send(ACT_BYTE, SOCKS_VER);
    send(ACT_BYTE, 8'h01);
    send(ACT_BYTE, METHOD_NO_AUTH);
    send(ACT_BYTE, SOCKS_VER);
    send(ACT_BYTE, CMD_CONNECT);
    send(ACT_BYTE, RSV_BYTE);
    send(ACT_BYTE, ATYP_DOMAIN);
    send(ACT_BYTE, ZERO_BYTE);
    send(ACT_BYTE, 8'hFF);
    send(ACT_BYTE, 8'hFF);
    // Transport error inside a session.
    send(ACT_START, 8'h00);
    send(ACT_BYTE, SOCKS_VER);
    send(ACT_ERROR, 8'h00);

    while (accepted_items < ITEM_TARGET) begin
      if (accepted_items > ITEM_TARGET * 9 / 10) calm = 1'b1;
      random_session();
      sessions++;
      if (sessions % 8 == 0) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (tracker.pending() != 0);
      end
    end
    calm = 1'b1;
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (20) @(posedge clk_i);

    if (tracker.pending() != 0)
      tracker.flag($sformatf("%0d expected results never arrived", tracker.pending()));
    $display("Ran %0d random sessions plus directed ones, %0d input transactions, %0d results.",
             sessions, accepted_items, tracker.checked);
    $display({"Results by kind: %0d reply, %0d domain byte, %0d ipv4, %0d domain, ",
              "%0d denied, %0d link error."},
             tracker.seen[EV_REPLY], tracker.seen[EV_DBYTE], tracker.seen[EV_IPV4],
             tracker.seen[EV_DOMAIN], tracker.seen[EV_DENIED], tracker.seen[EV_LINKERR]);
    if (tracker.errors == 0) begin
      $display("socks5_handshake_parser_core: match");
    end else begin
      $display("socks5_handshake_parser_core: mismatch");
    end
    $finish;
  end

endmodule
